// ----- sv/sbg_pkg.sv -----
// Shared types, codes and the decimal digit step of the sensor report block.
`default_nettype none
package sbg_pkg;

	// Received command characters.
	localparam logic [7:0] CMD_CONT   = 8'h43;
	localparam logic [7:0] CMD_STOP   = 8'h53;
	localparam logic [7:0] CMD_BURST  = 8'h50;
	localparam logic [7:0] CMD_SINGLE = 8'h31;

	// Report characters.
	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] SPACE_CHAR = 8'd32;

	// Reset values of the configuration registers.
	localparam logic [11:0] LEVEL_ONE_RST   = 12'd150;
	localparam logic [11:0] LEVEL_TWO_RST   = 12'd1000;
	localparam logic [11:0] LEVEL_THREE_RST = 12'd2000;
	localparam logic [11:0] LEVEL_FOUR_RST  = 12'd3000;
	localparam logic [7:0]  BURST_LEN_RST   = 8'd20;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_LEVEL_ONE    = 3'd0,
		CFG_LEVEL_TWO    = 3'd1,
		CFG_LEVEL_THREE  = 3'd2,
		CFG_LEVEL_FOUR   = 3'd3,
		CFG_BURST_LENGTH = 3'd4
	} cfg_idx_t;

	// Decimal places, most significant first.
	typedef enum logic [1:0] {
		PLACE_THOUSANDS = 2'd0,
		PLACE_HUNDREDS  = 2'd1,
		PLACE_TENS      = 2'd2,
		PLACE_ONES      = 2'd3
	} place_t;

	// One classified tick, as it waits in the queue.
	typedef struct packed {
		logic        report;
		logic [11:0] value;
		logic [3:0]  leds;
	} entry_t;

	// Front to queue write side.
	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_push_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Result of one decimal digit step.
	typedef struct packed {
		logic [3:0]  digit;
		logic [11:0] rem;
	} digit_t;

	// Extracts the digit at one place from a remainder below ten times that place.
	function automatic digit_t digit_step(logic [11:0] value, place_t place);
		digit_t      r;
		logic [13:0] pv;
		logic [13:0] thr;
		unique case (place)
			PLACE_THOUSANDS: pv = 14'd1000;
			PLACE_HUNDREDS:  pv = 14'd100;
			PLACE_TENS:      pv = 14'd10;
			PLACE_ONES:      pv = 14'd1;
		endcase
		r.digit = 4'd0;
		r.rem   = value;
		for (int m = 1; m <= 9; m++) begin
			thr = 14'(m) * pv;
			if ({2'b00, value} >= thr) begin
				r.digit = 4'(m);
				r.rem   = 12'({2'b00, value} - thr);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/sensor_report_bar_graph.sv -----
// Top level of the sensor report and bar graph block.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    operation, command_byte, sample
//  result    out        result_valid / result_stall char_valid, text_char, bar_leds, last
//  config    in         cfg_write                  cfg_index, cfg_data
//
// An item is taken every cycle while the tick queue has room; commands act at once.
// A reporting tick gives four words and a quiet tick one; the output register sends
// one word a cycle while the receiver does not stall.
// The queue holds QUEUE_DEPTH ticks so the front keeps taking items during a stall.
// Reset clears the mode, the burst count, the held sample and the queue at once.
// A stalled result word holds until taken; a full queue stalls the item channel.
`default_nettype none
module sensor_report_bar_graph #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        operation,
	input  wire logic [7:0]  command_byte,
	input  wire logic [11:0] sample,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             char_valid,
	output logic [7:0]       text_char,
	output logic [3:0]       bar_leds,
	output logic             last,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	import sbg_pkg::*;

	q_push_t   q_push;
	q_status_t q_status;
	entry_t    head;
	logic      pop;

	sbg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.command_byte (command_byte),
		.sample       (sample),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_status     (q_status),
		.q_push       (q_push)
	);

	sbg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	sbg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.char_valid   (char_valid),
		.text_char    (text_char),
		.bar_leds     (bar_leds),
		.last         (last)
	);

endmodule
`default_nettype wire

// ----- sv/sbg_front.sv -----
// Front part: takes items, runs the command state and classifies each tick.
`default_nettype none
module sbg_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic              operation,
	input  wire logic [7:0]        command_byte,
	input  wire logic [11:0]       sample,
	input  wire logic              cfg_write,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [11:0]       cfg_data,
	input  wire sbg_pkg::q_status_t q_status,
	output sbg_pkg::q_push_t       q_push
);
	import sbg_pkg::*;

	logic [11:0] level_one_q, level_two_q, level_three_q, level_four_q;
	logic [7:0]  burst_len_q;
	logic        cont_q;
	logic [7:0]  left_q;
	logic [11:0] held_q;

	logic        accept;
	logic        report;
	logic [11:0] held_new;
	logic [3:0]  leds;

	// A tick can only be taken when the queue has room.
	assign item_stall = q_status.full;
	assign accept     = item_valid && !item_stall;

	// Classify a tick and form the bar pattern from the updated sample.
	always_comb begin
		report   = cont_q || (left_q != 8'd0);
		held_new = report ? sample : held_q;
		leds     = 4'b0000;
		if (held_new > level_one_q)   leds = leds | 4'b0001;
		if (held_new > level_two_q)   leds = leds | 4'b0011;
		if (held_new > level_three_q) leds = leds | 4'b0111;
		if (held_new > level_four_q)  leds = leds | 4'b1111;
		q_push.push         = accept && operation;
		q_push.entry.report = report;
		q_push.entry.value  = held_new;
		q_push.entry.leds   = leds;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_one_q   <= LEVEL_ONE_RST;
			level_two_q   <= LEVEL_TWO_RST;
			level_three_q <= LEVEL_THREE_RST;
			level_four_q  <= LEVEL_FOUR_RST;
			burst_len_q   <= BURST_LEN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_LEVEL_ONE:    level_one_q   <= cfg_data;
				CFG_LEVEL_TWO:    level_two_q   <= cfg_data;
				CFG_LEVEL_THREE:  level_three_q <= cfg_data;
				CFG_LEVEL_FOUR:   level_four_q  <= cfg_data;
				CFG_BURST_LENGTH: burst_len_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Reporting mode, burst count and held sample; any other byte is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= 1'b0;
			left_q <= 8'd0;
			held_q <= 12'd0;
		end else if (accept) begin
			if (!operation) begin
				if (command_byte == CMD_CONT) begin
					cont_q <= 1'b1;
					left_q <= 8'd0;
				end else if (command_byte == CMD_STOP) begin
					cont_q <= 1'b0;
					left_q <= 8'd0;
				end else if (command_byte == CMD_BURST) begin
					cont_q <= 1'b0;
					left_q <= burst_len_q;
				end else if (command_byte == CMD_SINGLE) begin
					cont_q <= 1'b0;
					left_q <= 8'd1;
				end
			end else begin
				held_q <= held_new;
				if (!cont_q && left_q != 8'd0) begin
					left_q <= left_q - 8'd1;
				end
			end
		end
	end

	// Continuous mode and a burst count never coexist.
	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cont_q |-> (left_q == 8'd0))
		else $error("burst count left over in continuous mode");

	// A tick in continuous mode is always queued as a report.
	a_cont_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation && cont_q) |-> (q_push.push && q_push.entry.report))
		else $error("continuous tick not reported");

	// A burst counts down by one on each taken tick.
	a_burst_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation && !cont_q && left_q != 8'd0) |=>
		(left_q == $past(left_q) - 8'd1))
		else $error("burst count did not step");

endmodule
`default_nettype wire

// ----- sv/sbg_queue.sv -----
// Short queue of classified ticks between the front and back parts.
`default_nettype none
module sbg_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sbg_pkg::q_push_t q_push,
	input  wire logic             pop,
	output sbg_pkg::entry_t       head,
	output sbg_pkg::q_status_t    q_status
);
	import sbg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t          store_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign q_status.empty = (cnt_q == '0);
	assign q_status.full  = (cnt_q == FULL_CNT);
	assign do_push        = q_push.push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head           = store_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_q] <= q_push.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.push |-> !q_status.full)
		else $error("push into full queue");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// Count grows by one on a push without a pop.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("queue count did not grow on push");

endmodule
`default_nettype wire

// ----- sv/sbg_back.sv -----
// Back part: turns each queued tick into one or four result words.
`default_nettype none
module sbg_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sbg_pkg::entry_t    head,
	input  wire sbg_pkg::q_status_t q_status,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    char_valid,
	output logic [7:0]              text_char,
	output logic [3:0]              bar_leds,
	output logic                    last
);
	import sbg_pkg::*;

	logic        rv_q;
	logic        cv_q;
	logic [7:0]  text_q;
	logic [3:0]  leds_q;
	logic        last_q;
	place_t      pos_q;
	logic [11:0] rem_q;
	logic        lead_q;

	logic        load, take, final_word;
	logic [11:0] cur_rem;
	logic        cur_lead;
	digit_t      dstep;
	logic [7:0]  ch;

	// Next digit of the current report, most significant first.
	always_comb begin
		cur_rem    = (pos_q == PLACE_THOUSANDS) ? head.value : rem_q;
		cur_lead   = (pos_q == PLACE_THOUSANDS) ? 1'b1 : lead_q;
		dstep      = digit_step(cur_rem, pos_q);
		if (cur_lead && dstep.digit == 4'd0 && pos_q != PLACE_ONES) begin
			ch = SPACE_CHAR;
		end else begin
			ch = DIGIT_BASE + {4'd0, dstep.digit};
		end
		final_word = !head.report || (pos_q == PLACE_ONES);
		load       = !rv_q || !result_stall;
		take       = load && !q_status.empty;
		pop        = take && final_word;
	end

	// Output word valid and digit position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q   <= 1'b0;
			pos_q  <= PLACE_THOUSANDS;
			lead_q <= 1'b1;
		end else begin
			if (load) begin
				rv_q <= !q_status.empty;
			end
			if (take) begin
				if (final_word) begin
					pos_q <= PLACE_THOUSANDS;
				end else begin
					pos_q  <= place_t'(pos_q + 2'd1);
					lead_q <= cur_lead && (dstep.digit == 4'd0);
				end
			end
		end
	end

	// Output word payload and digit remainder.
	always_ff @(posedge clk) begin
		if (take) begin
			cv_q   <= head.report;
			text_q <= head.report ? ch : 8'd0;
			leds_q <= head.leds;
			last_q <= final_word;
			rem_q  <= dstep.rem;
		end
	end

	assign result_valid = rv_q;
	assign char_valid   = cv_q;
	assign text_char    = text_q;
	assign bar_leds     = leds_q;
	assign last         = last_q;

	// A word with no character is always the only word of its tick.
	a_idle_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && !cv_q) |-> last_q)
		else $error("non-report word without last");

	// With nothing queued the position sits at the first place.
	a_pos_home: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> (pos_q == PLACE_THOUSANDS))
		else $error("digit position left mid-report");

	// A report character is a digit or a space.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && cv_q) |-> (text_q == SPACE_CHAR ||
		(text_q >= DIGIT_BASE && text_q <= DIGIT_BASE + 8'd9)))
		else $error("report character out of range");

endmodule
`default_nettype wire

// ----- tb/sv/sensor_report_bar_graph_tb.sv -----
// Self-checking testbench for the sensor report and bar graph block.
module sensor_report_bar_graph_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbg_pkg::*;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;
	localparam int   STALL_LIMIT = 3000;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   SEGMENT_ITEMS = 31;

	// One word on the result channel.
	typedef struct {
		logic       char_valid;
		logic [7:0] text_char;
		logic [3:0] bar_leds;
		logic       last;
	} word_t;

	// Keeps its own copy of the mode, burst count, held sample and levels,
	// and the words that the block still owes.
	class report_scoreboard;
		logic [11:0] level [4];
		logic [7:0]  burst_len;
		bit          continuous;
		logic [7:0]  burst_left;
		logic [11:0] held;
		word_t       owed [$];
		int          errors, ticks, reports, commands, words;

		function new();
			level[0]   = LEVEL_ONE_RST;
			level[1]   = LEVEL_TWO_RST;
			level[2]   = LEVEL_THREE_RST;
			level[3]   = LEVEL_FOUR_RST;
			burst_len  = BURST_LEN_RST;
			continuous = 1'b0;
			burst_left = '0;
			held       = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [11:0] data);
			case (idx)
				CFG_LEVEL_ONE:    level[0] = data;
				CFG_LEVEL_TWO:    level[1] = data;
				CFG_LEVEL_THREE:  level[2] = data;
				CFG_LEVEL_FOUR:   level[3] = data;
				CFG_BURST_LENGTH: burst_len = data[7:0];
				default: ;
			endcase
		endfunction

		// Each exceeded level lights its own bits; the bits are ORed together.
		function logic [3:0] thermometer(logic [11:0] v);
			logic [3:0] leds;
			leds = 4'b0000;
			if (v > level[0]) leds |= 4'b0001;
			if (v > level[1]) leds |= 4'b0011;
			if (v > level[2]) leds |= 4'b0111;
			if (v > level[3]) leds |= 4'b1111;
			return leds;
		endfunction

		function void note_item(logic op, logic [7:0] cmd, logic [11:0] smp);
			bit         show;
			logic [3:0] leds;
			logic [7:0] txt [4];
			logic [11:0] v;
			word_t      w;
			if (op == OP_COMMAND) begin
				case (cmd)
					CMD_CONT: begin
						continuous = 1'b1;
						burst_left = '0;
					end
					CMD_STOP: begin
						continuous = 1'b0;
						burst_left = '0;
					end
					CMD_BURST: begin
						continuous = 1'b0;
						burst_left = burst_len;
					end
					CMD_SINGLE: begin
						continuous = 1'b0;
						burst_left = 8'd1;
					end
					default: ;
				endcase
				commands++;
				return;
			end
			ticks++;
			show = continuous || (burst_left != 0);
			if (!continuous && burst_left != 0)
				burst_left = burst_left - 8'd1;
			if (show)
				held = smp;
			leds = thermometer(held);
			if (!show) begin
				w = '{1'b0, 8'd0, leds, 1'b1};
				owed.push_back(w);
				return;
			end
			reports++;
			// Right-aligned decimal; leading zeros become spaces, the ones place never does.
			v = held;
			for (int k = 3; k >= 0; k--) begin
				if (k == 3 || v != 0) begin
					txt[k] = DIGIT_BASE + 8'(v % 10);
					v = v / 10;
				end else begin
					txt[k] = SPACE_CHAR;
				end
			end
			for (int k = 0; k < 4; k++) begin
				w = '{1'b1, txt[k], leds, (k == 3)};
				owed.push_back(w);
			end
		endfunction

		function void check_word(logic cv, logic [7:0] ch, logic [3:0] leds, logic lst);
			word_t w;
			if (owed.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
				return;
			end
			w = owed.pop_front();
			words++;
			if (cv !== w.char_valid) begin
				$error("char_valid: expected %0d, got %0d", w.char_valid, cv);
				errors++;
			end
			if (ch !== w.text_char) begin
				$error("text_char: expected 0x%02h, got 0x%02h", w.text_char, ch);
				errors++;
			end
			if (leds !== w.bar_leds) begin
				$error("bar_leds: expected 0x%01h, got 0x%01h", w.bar_leds, leds);
				errors++;
			end
			if (lst !== w.last) begin
				$error("last: expected %0d, got %0d", w.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        operation = OP_COMMAND;
	logic [7:0]  command_byte = 8'd0;
	logic [11:0] sample = 12'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        char_valid;
	logic [7:0]  text_char;
	logic [3:0]  bar_leds;
	logic        last;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = CFG_LEVEL_ONE;
	logic [11:0] cfg_data = 12'd0;

	int send_idle = 0;
	int recv_idle = 0;
	int idle_cycles = 0;
	int settings = 0;

	report_scoreboard sb = new();

	sensor_report_bar_graph dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.command_byte(command_byte),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.char_valid(char_valid),
		.text_char(text_char),
		.bar_leds(bar_leds),
		.last(last),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random at the chosen rate.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle);
	end

	// Both handshakes are observed here, on values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(operation, command_byte, sample);
			if (result_valid && !result_stall)
				sb.check_word(char_valid, text_char, bar_leds, last);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Ends the run when neither channel has moved for too long.
	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// Offers one item, with random idle cycles first, and returns once it is taken.
	task automatic send_item(logic op, logic [7:0] cmd, logic [11:0] smp);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		operation    <= op;
		command_byte <= cmd;
		sample       <= smp;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_command(logic [7:0] cmd);
		send_item(OP_COMMAND, cmd, 12'($urandom));
	endtask

	task automatic send_tick(logic [11:0] smp);
		send_item(OP_TICK, 8'($urandom), smp);
	endtask

	// Lets every owed word arrive, then lets commands in flight settle.
	// The first edge makes sure the last accepted item has been noted.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all five registers on consecutive cycles; the block is idle here.
	task automatic load_regs(logic [11:0] l1, logic [11:0] l2, logic [11:0] l3,
			logic [11:0] l4, logic [7:0] burst);
		logic [11:0] vals [5];
		vals[0] = l1;
		vals[1] = l2;
		vals[2] = l3;
		vals[3] = l4;
		// Upper bits of the burst register write are don't-care.
		vals[4] = {4'($urandom), burst};
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(cfg_idx_t'(i), vals[i]);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	// Samples lean toward the extremes and the edges of the current levels.
	function automatic logic [11:0] pick_sample();
		logic [11:0] lv;
		lv = sb.level[$urandom_range(3)];
		case ($urandom_range(5))
			0: return 12'd0;
			1: return 12'hFFF;
			2: return lv + 12'($urandom_range(2)) - 12'd1;
			default: return 12'($urandom);
		endcase
	endfunction

	// Mostly the four commands and ticks, with some unknown bytes as noise.
	task automatic random_segment(int count);
		int done;
		done = 0;
		while (done < count) begin
			case ($urandom_range(19))
				0, 1, 2: begin
					send_command(8'($urandom));
					done++;
				end
				3: begin
					send_command(CMD_CONT);
					done++;
				end
				4: begin
					send_command(CMD_STOP);
					done++;
				end
				5, 6: begin
					send_command(CMD_BURST);
					done++;
				end
				7, 8: begin
					send_command(CMD_SINGLE);
					done++;
				end
				default: begin
					send_tick(pick_sample());
					done++;
				end
			endcase
		end
	endtask

	// Reset, directed items, then six register settings over three idling modes.
	initial begin
		logic [11:0] a, b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset register values: quiet ticks, single, continuous,
		// zero sample, level edges, stop, burst and ignored bytes.
		send_tick(12'd0);
		send_command(CMD_SINGLE);
		send_tick(12'hFFF);
		send_tick(12'd77);
		send_command(CMD_CONT);
		send_tick(12'd0);
		send_tick(12'd5);
		send_tick(12'd42);
		send_tick(12'd999);
		send_tick(12'd1000);
		send_tick(12'd1001);
		send_tick(12'd150);
		send_tick(12'd151);
		send_tick(12'd3001);
		send_command(CMD_STOP);
		send_tick(12'd2500);
		send_command(8'h00);
		send_command(8'hFF);
		send_command(8'h78);
		send_tick(12'd2001);
		send_command(CMD_BURST);
		send_tick(12'd2000);
		send_tick(12'd3000);
		send_command(CMD_SINGLE);
		send_command(CMD_BURST);
		send_tick(12'd1);
		drain();

		for (int seg = 0; seg < 6; seg++) begin
			send_idle = (seg < 2) ? 35 : (seg < 4) ? 69 : 0;
			recv_idle = (seg < 2) ? 69 : (seg < 4) ? 35 : 0;
			a = 12'($urandom);
			b = 12'($urandom);
			case (seg)
				0: load_regs(12'd0, 12'd0, 12'd0, 12'd0, 8'd255);
				1: load_regs(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'd0);
				2: load_regs(12'd3000, 12'd2000, 12'd1000, 12'd150, 8'd1);
				3: load_regs(a < b ? a : b, a < b ? b : a, 12'hC00, 12'hFFE,
						8'($urandom_range(2, 8)));
				4: load_regs(12'($urandom), 12'($urandom), 12'($urandom),
						12'($urandom), 8'($urandom_range(1, 255)));
				default: load_regs(LEVEL_ONE_RST, LEVEL_TWO_RST, LEVEL_THREE_RST,
						LEVEL_FOUR_RST, BURST_LEN_RST);
			endcase
			random_segment(SEGMENT_ITEMS);
			drain();
		end

		$display("Run covered %0d ticks (%0d reporting) and %0d commands, %0d result words,",
			sb.ticks, sb.reports, sb.commands, sb.words);
		$display("under %0d register settings with mixed idle and stall rates.", settings);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sbg_pkg.sv
sv/sbg_front.sv
sv/sbg_queue.sv
sv/sbg_back.sv
sv/sensor_report_bar_graph.sv
tb/sv/sensor_report_bar_graph_tb.sv
